>>> design/sefb_pkg.sv
// Shared types, widths and codes of the stereo echo core with FIR feedback.
// Used by the ring memory, the filter datapath, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps

package sefb_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 8;
  localparam int GAIN_W      = 8;
  localparam int TAP_COUNT   = 8;
  localparam int TAP_IDX_W   = 3;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_W       = PROD_W + TAP_IDX_W;
  localparam int SCALED_W    = ACC_W + GAIN_W;
  localparam int GAIN_SHIFT  = 14;
  localparam int COEFS_W     = TAP_COUNT * COEF_W;
  localparam int DELAY_W     = 4;
  localparam int CFG_IDX_W   = 3;

  // Coefficient applied to the newest history word.
  localparam logic [TAP_IDX_W-1:0] TAP_NEWEST_COEF = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_STEPS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_RIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFS        = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry_left;
    logic signed [SAMPLE_W-1:0] dry_right;
  } sefb_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_left;
    logic signed [SAMPLE_W-1:0] mixed_right;
  } sefb_out_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } sefb_pair_t;

  typedef struct packed {
    logic                 push;
    logic                 mac_en;
    logic                 mac_clr;
    logic [TAP_IDX_W-1:0] tap;
    logic                 mix_en;
    logic                 fb_en;
  } sefb_fir_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAC,
    ST_MIX,
    ST_FEED,
    ST_DONE
  } sefb_state_t;

endpackage

>>> design/sefb_ring.sv
// Echo ring memory: one write port, one registered read port, and a fill mark.
// Entries at or above the fill mark have never been written and read as zero.
// Depends on sefb_pkg.
`timescale 1ns / 1ps

module sefb_ring #(
  parameter int DEPTH = 7680,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output sefb_pkg::sefb_pair_t rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  sefb_pkg::sefb_pair_t wr_data
);
  import sefb_pkg::*;

  sefb_pair_t      mem [DEPTH];
  sefb_pair_t      rd_raw_r;
  logic            rd_valid_r;
  logic [CW-1:0]   fill_r;
  logic [CW-1:0]   fill_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_addr];
    end
  end

  // The ring position only steps by one or returns to zero, so the written
  // entries always form one run starting at zero.
  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && (CW'(wr_addr) >= fill_r)) begin
      fill_nxt = CW'(wr_addr) + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (rd_en) begin
        rd_valid_r <= (CW'(rd_addr) < fill_r);
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_raw_r : '0;

endmodule

>>> design/sefb_fir.sv
// Filter datapath: 8-word history, one-tap-per-cycle MAC for both channels,
// shared gain multipliers and the saturating mix.
// Depends on sefb_pkg.
`timescale 1ns / 1ps

module sefb_fir (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sefb_pkg::sefb_fir_ctrl_t            ctrl,
  input  sefb_pkg::sefb_pair_t                echo,
  input  sefb_pkg::sefb_pair_t                dry,
  input  logic [sefb_pkg::COEFS_W-1:0]        coefs,
  input  logic signed [sefb_pkg::GAIN_W-1:0]  vol_left,
  input  logic signed [sefb_pkg::GAIN_W-1:0]  vol_right,
  input  logic signed [sefb_pkg::GAIN_W-1:0]  fb_gain,
  output sefb_pkg::sefb_pair_t                mixed,
  output sefb_pkg::sefb_pair_t                fed
);
  import sefb_pkg::*;

  localparam int SH_W  = SCALED_W - GAIN_SHIFT;
  localparam int SUM_W = SH_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

  sefb_pair_t                  hist_r [TAP_COUNT];
  sefb_pair_t                  hist_tap;
  logic [TAP_IDX_W-1:0]        coef_idx;
  logic signed [COEF_W-1:0]    coef;
  logic signed [PROD_W-1:0]    prod_l;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [ACC_W-1:0]     acc_l_r;
  logic signed [ACC_W-1:0]     acc_r_r;
  logic signed [ACC_W-1:0]     acc_l_nxt;
  logic signed [ACC_W-1:0]     acc_r_nxt;
  logic signed [GAIN_W-1:0]    gain_l;
  logic signed [GAIN_W-1:0]    gain_r;
  logic signed [SCALED_W-1:0]  mul_l;
  logic signed [SCALED_W-1:0]  mul_r;
  logic signed [SCALED_W-1:0]  mix_l_r;
  logic signed [SCALED_W-1:0]  mix_r_r;
  logic signed [SCALED_W-1:0]  fb_l_r;
  logic signed [SCALED_W-1:0]  fb_r_r;

  // Floor of p / 2^14 added to the dry sample, then clamped to 16 bits.
  function automatic logic signed [SAMPLE_W-1:0] sat_mix(
    input logic signed [SAMPLE_W-1:0] d,
    input logic signed [SCALED_W-1:0] p
  );
    logic signed [SH_W-1:0]  sh;
    logic signed [SUM_W-1:0] sum;
    sh  = p[SCALED_W-1:GAIN_SHIFT];
    sum = SUM_W'(d) + SUM_W'(sh);
    if (sum > SAT_HI) begin
      return SAT_HI[SAMPLE_W-1:0];
    end else if (sum < SAT_LO) begin
      return SAT_LO[SAMPLE_W-1:0];
    end
    return sum[SAMPLE_W-1:0];
  endfunction

  // History as a shift line: entry 0 is the newest echo word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        hist_r[i] <= '0;
      end
    end else if (ctrl.push) begin
      hist_r[0] <= echo;
      for (int i = 1; i < TAP_COUNT; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  assign hist_tap = hist_r[ctrl.tap];
  assign coef_idx = TAP_NEWEST_COEF - ctrl.tap;
  assign coef     = $signed(coefs[{coef_idx, 3'b000} +: COEF_W]);
  assign prod_l   = $signed(hist_tap.left) * coef;
  assign prod_r   = $signed(hist_tap.right) * coef;

  assign acc_l_nxt = ctrl.mac_clr ? ACC_W'(prod_l) : acc_l_r + ACC_W'(prod_l);
  assign acc_r_nxt = ctrl.mac_clr ? ACC_W'(prod_r) : acc_r_r + ACC_W'(prod_r);

  // Two multipliers serve the wet volumes first, then the feedback gain.
  assign gain_l = ctrl.fb_en ? fb_gain : vol_left;
  assign gain_r = ctrl.fb_en ? fb_gain : vol_right;
  assign mul_l  = acc_l_r * gain_l;
  assign mul_r  = acc_r_r * gain_r;

  always_ff @(posedge clk) begin
    if (ctrl.mac_en) begin
      acc_l_r <= acc_l_nxt;
      acc_r_r <= acc_r_nxt;
    end
    if (ctrl.mix_en) begin
      mix_l_r <= mul_l;
      mix_r_r <= mul_r;
    end
    if (ctrl.fb_en) begin
      fb_l_r <= mul_l;
      fb_r_r <= mul_r;
    end
  end

  assign mixed.left  = sat_mix(dry.left,  mix_l_r);
  assign mixed.right = sat_mix(dry.right, mix_r_r);
  assign fed.left    = sat_mix(dry.left,  fb_l_r);
  assign fed.right   = sat_mix(dry.right, fb_r_r);

endmodule

>>> design/stereo_echo_fir_feedback_core.sv
// Stereo echo core with an 8-tap FIR in the feedback path.
// out_valid rises once an accepted word has passed fetch, MAC, mix, feed and done.
// One word is in flight at a time; the single-tap-per-cycle MAC sets the pace.
// Reset (rst_n, synchronous, active low) clears the configuration, the sequencer,
// the history and the ring fill mark, so the ring reads as silence at once.
// Depends on sefb_pkg, sefb_ring and sefb_fir.
`timescale 1ns / 1ps

module stereo_echo_fir_feedback_core #(
  parameter int MAX_DELAY_STEPS = 15,
  parameter int PAIRS_PER_STEP  = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sefb_pkg::sefb_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sefb_pkg::sefb_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sefb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sefb_pkg::COEFS_W-1:0]     cfg_data
);
  import sefb_pkg::*;

  localparam int RING_PAIRS = MAX_DELAY_STEPS * PAIRS_PER_STEP;
  localparam int AW         = $clog2(RING_PAIRS);
  localparam int CW         = $clog2(RING_PAIRS + 1);

  // Configuration registers.
  logic [DELAY_W-1:0]        delay_r;
  logic signed [GAIN_W-1:0]  fb_gain_r;
  logic signed [GAIN_W-1:0]  vol_left_r;
  logic signed [GAIN_W-1:0]  vol_right_r;
  logic [COEFS_W-1:0]        coefs_r;

  // Sequencer and per-word state.
  sefb_state_t               state_r;
  sefb_state_t               state_nxt;
  logic [TAP_IDX_W-1:0]      tap_r;
  logic [TAP_IDX_W-1:0]      tap_nxt;
  logic [AW-1:0]             pos_r;
  logic [AW-1:0]             pos_nxt;
  logic [AW-1:0]             idx;
  logic [AW-1:0]             idx_r;
  logic [CW-1:0]             idx_inc;
  logic [DELAY_W-1:0]        steps_sat;
  logic [CW-1:0]             limit;
  sefb_pair_t                dry_r;
  sefb_out_t                 out_data_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;

  logic                      in_acc;
  logic                      out_load;
  logic                      rd_en;
  logic                      wr_en;
  sefb_fir_ctrl_t            fir_ctrl;
  sefb_pair_t                echo_word;
  sefb_pair_t                mixed;
  sefb_pair_t                fed;

  // The configuration port only takes a write while no word is in flight, and
  // an input word offered in the same cycle goes first.
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r     <= '0;
      fb_gain_r   <= '0;
      vol_left_r  <= '0;
      vol_right_r <= '0;
      coefs_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELAY_STEPS: delay_r     <= cfg_data[DELAY_W-1:0];
        CFG_FEEDBACK:    fb_gain_r   <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_VOL_LEFT:    vol_left_r  <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_VOL_RIGHT:   vol_right_r <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_COEFS:       coefs_r     <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Ring position. The ring length is the delay setting times the step size,
  // with the setting saturated at the largest supported delay. A zero delay
  // pins the position at entry zero. A position left beyond a newly shortened
  // ring is still used once and then wraps to zero on this same compare.
  assign steps_sat = (delay_r > DELAY_W'(MAX_DELAY_STEPS)) ?
                     DELAY_W'(MAX_DELAY_STEPS) : delay_r;
  assign limit     = CW'(CW'(steps_sat) * CW'(PAIRS_PER_STEP));
  assign idx       = (CW'(pos_r) >= CW'(RING_PAIRS)) ? '0 : pos_r;
  assign idx_inc   = CW'(idx) + CW'(1);
  assign pos_nxt   = (idx_inc >= limit) ? '0 : AW'(idx_inc);

  assign in_acc = in_valid && in_ready;

  // Next-state logic. One word is in flight at a time: fetch the delayed pair,
  // run the MAC over all eight taps, apply the two gains, then write back and present.
  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_MAC;
        tap_nxt   = '0;
      end
      ST_MAC: begin
        tap_nxt = tap_r + TAP_IDX_W'(1);
        if (tap_r == TAP_IDX_W'(TAP_COUNT - 1)) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        state_nxt = ST_FEED;
      end
      ST_FEED: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_ready         = 1'b0;
    rd_en            = 1'b0;
    wr_en            = 1'b0;
    out_load         = 1'b0;
    fir_ctrl         = '0;
    fir_ctrl.tap     = tap_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid;
      end
      ST_FETCH: begin
        fir_ctrl.push = 1'b1;
      end
      ST_MAC: begin
        fir_ctrl.mac_en  = 1'b1;
        fir_ctrl.mac_clr = (tap_r == '0);
      end
      ST_MIX: begin
        fir_ctrl.mix_en = 1'b1;
      end
      ST_FEED: begin
        fir_ctrl.fb_en = 1'b1;
      end
      ST_DONE: begin
        // The ring entry is written back only when the result moves into the
        // output register, so a stall here simply holds everything in place.
        wr_en    = !out_valid_r || out_ready;
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      if (in_acc) begin
        pos_r <= pos_nxt;
      end
    end
  end

  // Word payload held for the whole computation.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r       <= idx;
      dry_r.left  <= in_data.dry_left;
      dry_r.right <= in_data.dry_right;
    end
  end

  // The read and the write of one word never overlap with those of the next,
  // since the next word is only taken after the write-back.
  sefb_ring #(
    .DEPTH (RING_PAIRS)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (echo_word),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (fed)
  );

  sefb_fir u_fir (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (fir_ctrl),
    .echo      (echo_word),
    .dry       (dry_r),
    .coefs     (coefs_r),
    .vol_left  (vol_left_r),
    .vol_right (vol_right_r),
    .fb_gain   (fb_gain_r),
    .mixed     (mixed),
    .fed       (fed)
  );

  // Output register; it frees the sequencer to take the next word while a
  // result still waits for the consumer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.mixed_left  <= mixed.left;
      out_data_r.mixed_right <= mixed.right;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/sefb_checker.sv
// Port-level checker for the stereo echo core, bound to the top level.
// Depends on sefb_pkg and stereo_echo_fir_feedback_core.
`timescale 1ns / 1ps

module sefb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sefb_pkg::sefb_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_no_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after its input word");

endmodule

bind stereo_echo_fir_feedback_core sefb_checker u_sefb_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for stereo_echo_fir_feedback_core: directed and random
// stereo words are predicted with a local echo ring, FIR history and mixer model.
// Depends on sefb_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import sefb_pkg::*;

  localparam int MAX_DELAY_STEPS = 15;
  localparam int PAIRS_PER_STEP  = 512;
  localparam int RING_PAIRS      = MAX_DELAY_STEPS * PAIRS_PER_STEP;
  localparam int HALF_PERIOD     = 6;
  // Cycles without any accepted word before the run is declared hung. The longest
  // legal quiet stretch is the forced receiver hold plus one pass through the core.
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 30;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_SPARSE,
    RX_RUNS
  } rx_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  sefb_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sefb_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COEFS_W-1:0]    cfg_data  = '0;

  stereo_echo_fir_feedback_core #(
    .MAX_DELAY_STEPS (MAX_DELAY_STEPS),
    .PAIRS_PER_STEP  (PAIRS_PER_STEP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Echo model. This is the testbench's own copy of the core's state: the echo
  // ring, its read/write position, the eight-deep FIR history and the register
  // file. It is updated only when a word is actually accepted by the core.
  // ---------------------------------------------------------------------------
  sefb_pair_t               echo_ring [RING_PAIRS];
  int                       ring_pos;
  sefb_pair_t               fir_hist [TAP_COUNT];
  int                       hist_pos;
  logic [DELAY_W-1:0]       delay_reg;
  logic signed [GAIN_W-1:0] feedback_reg;
  logic signed [GAIN_W-1:0] vol_left_reg;
  logic signed [GAIN_W-1:0] vol_right_reg;
  logic [COEFS_W-1:0]       coef_reg;

  sefb_out_t expected_mix_q [$];
  int        mismatch_count = 0;

  // Sender and receiver pacing.
  int  burst_left     = 0;
  bit  steady_sender  = 1'b0;
  bit  hold_request   = 1'b0;
  int  hold_left      = 0;
  int  idle_cycles    = 0;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[SAMPLE_W-1:0];
  endfunction

  // Runs one stereo word through the model and returns the mixed output pair.
  // The ring entry just read is replaced with the dry sample plus the filtered
  // echo scaled by the feedback gain; shifts floor toward minus infinity.
  function automatic sefb_out_t mix_echo_sample(input sefb_in_t dry);
    int         idx;
    int         steps;
    int         hp;
    int         k;
    longint     coef;
    longint     acc_l;
    longint     acc_r;
    sefb_out_t  mixed;
    idx = ring_pos;
    if (idx >= RING_PAIRS) idx = 0;
    steps = (int'(delay_reg) > MAX_DELAY_STEPS) ? MAX_DELAY_STEPS : int'(delay_reg);
    ring_pos = idx + 1;
    if (ring_pos >= steps * PAIRS_PER_STEP) ring_pos = 0;

    hp = hist_pos % TAP_COUNT;
    fir_hist[hp] = echo_ring[idx];
    hist_pos = (hp + TAP_COUNT - 1) % TAP_COUNT;

    // The newest history word sits at hp and takes the highest tap.
    acc_l = 0;
    acc_r = 0;
    for (k = 0; k < TAP_COUNT; k++) begin
      coef = longint'($signed(coef_reg[COEF_W*(TAP_COUNT-1-k) +: COEF_W]));
      acc_l += longint'(fir_hist[(hp + k) % TAP_COUNT].left) * coef;
      acc_r += longint'(fir_hist[(hp + k) % TAP_COUNT].right) * coef;
    end

    mixed.mixed_left  = sat16(longint'(dry.dry_left)
                              + ((acc_l * longint'(vol_left_reg)) >>> GAIN_SHIFT));
    mixed.mixed_right = sat16(longint'(dry.dry_right)
                              + ((acc_r * longint'(vol_right_reg)) >>> GAIN_SHIFT));
    echo_ring[idx].left  = sat16(longint'(dry.dry_left)
                                 + ((acc_l * longint'(feedback_reg)) >>> GAIN_SHIFT));
    echo_ring[idx].right = sat16(longint'(dry.dry_right)
                                 + ((acc_r * longint'(feedback_reg)) >>> GAIN_SHIFT));
    return mixed;
  endfunction

  // Register write as the model sees it; indexes past the coefficient word are
  // dropped by the core and must leave every setting alone.
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [COEFS_W-1:0] data);
    case (idx)
      CFG_DELAY_STEPS: delay_reg     = data[DELAY_W-1:0];
      CFG_FEEDBACK:    feedback_reg  = data[GAIN_W-1:0];
      CFG_VOL_LEFT:    vol_left_reg  = data[GAIN_W-1:0];
      CFG_VOL_RIGHT:   vol_right_reg = data[GAIN_W-1:0];
      CFG_COEFS:       coef_reg      = data;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offers one dry word and holds it until the core takes it. The sender works
  // in bursts; between bursts it drops valid for a random gap. Valid is left
  // high on return so back-to-back words need no second assignment per edge.
  task automatic send_dry(input logic [SAMPLE_W-1:0] left,
                          input logic [SAMPLE_W-1:0] right);
    int       gap;
    sefb_in_t w;
    w.dry_left  = left;
    w.dry_right = right;
    if (!steady_sender && burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    expected_mix_q.push_back(mix_echo_sample(w));
  endtask

  // Mostly random samples, with the rails and the values around zero mixed in
  // so the clamps and the sign handling get regular hits.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0:       return 8'h7F;
      1:       return 8'h80;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEFS_W-1:0] rand_coefs();
    case ($urandom_range(0, 7))
      0:       return {TAP_COUNT{8'h7F}};
      1:       return {TAP_COUNT{8'h80}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_words(input int count);
    int n;
    for (n = 0; n < count; n++) send_dry(rand_sample(), rand_sample());
  endtask

  // Lowers valid and waits until every predicted word has come back, so the
  // core is idle before its registers are touched.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_mix_q.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [COEFS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
  endtask

  // Writes all five registers. Unused upper bits of the narrow registers carry
  // random junk, which the core has to ignore.
  task automatic program_settings(input logic [DELAY_W-1:0] delay,
                                  input logic [GAIN_W-1:0] feedback,
                                  input logic [GAIN_W-1:0] vol_left,
                                  input logic [GAIN_W-1:0] vol_right,
                                  input logic [COEFS_W-1:0] coefs);
    logic [COEFS_W-1:0] junk;
    wait_results_drained();
    junk = {$urandom, $urandom};
    write_register(CFG_DELAY_STEPS, {junk[COEFS_W-1:DELAY_W], delay});
    junk = {$urandom, $urandom};
    write_register(CFG_FEEDBACK, {junk[COEFS_W-1:GAIN_W], feedback});
    junk = {$urandom, $urandom};
    write_register(CFG_VOL_LEFT, {junk[COEFS_W-1:GAIN_W], vol_left});
    junk = {$urandom, $urandom};
    write_register(CFG_VOL_RIGHT, {junk[COEFS_W-1:GAIN_W], vol_right});
    write_register(CFG_COEFS, coefs);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Straight out of reset every gain and tap is zero and the ring is silent, so
  // each dry word must come back unchanged.
  task automatic test_reset_passthrough();
    send_dry(16'h7FFF, 16'h8000);
    send_dry(16'h8000, 16'h7FFF);
    send_dry(16'h0000, 16'hFFFF);
    send_dry(16'hFFFF, 16'h0000);
    send_dry(16'h5555, 16'hAAAA);
    send_dry(16'h0001, 16'hFFFE);
  endtask

  // With zero delay the ring is a single pair that is read and rewritten every
  // word, so feedback builds up at once. Full-scale taps and gains of both
  // signs drive the FIR sum to its extremes and the outputs into both clamps.
  task automatic test_zero_delay_clamps();
    program_settings(4'd0, 8'h7F, 8'h7F, 8'h80, {TAP_COUNT{8'h7F}});
    send_dry(16'h7FFF, 16'h7FFF);
    send_dry(16'h7FFF, 16'h8000);
    send_dry(16'h8000, 16'h7FFF);
    send_dry(16'h8000, 16'h8000);
    send_dry(16'h0000, 16'h0000);
    program_settings(4'd0, 8'h80, 8'h80, 8'h7F, {TAP_COUNT{8'h80}});
    send_dry(16'h7FFF, 16'h8000);
    send_dry(16'h8000, 16'h7FFF);
    send_dry(16'h7FFF, 16'h7FFF);
    send_dry(16'h1234, 16'hEDCB);
    send_dry(16'hFFFF, 16'h0001);
  endtask

  // Writes to indexes past the coefficient word must change nothing.
  task automatic test_ignored_registers();
    int k;
    wait_results_drained();
    for (k = 1; k <= 3; k++)
      write_register(CFG_IDX_W'(CFG_COEFS + k), {$urandom, $urandom});
    cfg_valid <= 1'b0;
    send_dry(16'h4000, 16'hC000);
    send_dry(16'h7FFF, 16'h8000);
    send_dry(16'h0100, 16'hFF00);
  endtask

  // One step of delay: the ring wraps after 512 words, so the second lap reads
  // back echoes written by the first.
  task automatic test_ring_wrap();
    program_settings(4'd1, rand_gain(), rand_gain(), rand_gain(), rand_coefs());
    send_random_words(550);
  endtask

  // Run a two-step ring until the position lies past 512, then shorten the ring
  // to one step: the next access still uses the old position and then the
  // position must fall back to zero.
  task automatic test_shortened_ring();
    program_settings(4'd2, rand_gain(), rand_gain(), rand_gain(), rand_coefs());
    send_random_words(480);
    program_settings(4'd1, rand_gain(), rand_gain(), rand_gain(), rand_coefs());
    send_random_words(40);
  endtask

  // Longest ring with extreme gains. The receiver holds off for a long stretch
  // while the sender keeps offering words back to back, so the core fills up
  // and must stall its input without losing or duplicating anything.
  task automatic test_output_backpressure();
    program_settings(4'd15, 8'h80, 8'h7F, 8'h80, rand_coefs());
    steady_sender = 1'b1;
    hold_request  = 1'b1;
    send_random_words(40);
    steady_sender = 1'b0;
  endtask

  // A few short phases with every setting drawn at random, delay included.
  task automatic test_random_settings();
    int r;
    for (r = 0; r < 4; r++) begin
      program_settings(DELAY_W'($urandom), rand_gain(), rand_gain(), rand_gain(),
                       rand_coefs());
      send_random_words(15);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. It switches between always ready, scattered random stalls
  // and longer on/off runs, and honors a forced long hold when a test asks.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode      = RX_ALWAYS;
  int       rx_mode_left = 0;
  int       rx_run_left  = 0;
  bit       rx_stalled   = 1'b0;

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(50, 300);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (rx_run_left == 0) begin
            rx_stalled  = !rx_stalled;
            rx_run_left = rx_stalled ? $urandom_range(1, 24) : $urandom_range(1, 16);
          end
          rx_run_left--;
          out_ready <= !rx_stalled;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted output word is compared with the oldest
  // prediction. Handshake signals are read right after the edge, which gives
  // the values that the edge itself saw.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sefb_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_mix_q.size() == 0) begin
        $error("output word %h arrived with no prediction pending", out_data);
        mismatch_count++;
      end else begin
        want = expected_mix_q.pop_front();
        if (out_data.mixed_left !== want.mixed_left) begin
          $error("mixed_left: expected %0d, actual %0d", want.mixed_left,
                 out_data.mixed_left);
          mismatch_count++;
        end
        if (out_data.mixed_right !== want.mixed_right) begin
          $error("mixed_right: expected %0d, actual %0d", want.mixed_right,
                 out_data.mixed_right);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence. The model starts from the same cleared state as the core.
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    for (i = 0; i < RING_PAIRS; i++) echo_ring[i] = '0;
    for (i = 0; i < TAP_COUNT; i++) fir_hist[i] = '0;
    ring_pos      = 0;
    hist_pos      = 0;
    delay_reg     = '0;
    feedback_reg  = '0;
    vol_left_reg  = '0;
    vol_right_reg = '0;
    coef_reg      = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_passthrough();
    test_zero_delay_clamps();
    test_ignored_registers();
    test_ring_wrap();
    test_shortened_ring();
    test_output_backpressure();
    test_random_settings();

    // Let the last words come back, then give any stray output time to show up.
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
